[hw/rtl/rfa_pkg.sv]
`timescale 1ns / 1ps
package rfa_pkg;

  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int FRAME_COUNT_DEF = 8192;

  localparam int ADDR_W   = 32;
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 8;
  localparam int PAGES_W  = 14;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 2'd1;

  typedef struct packed {
    logic busy;
    logic wr;
    logic done;
    logic restart;
  } rfa_clr_t;

endpackage

[hw/rtl/rfa_ram.sv]
`timescale 1ns / 1ps
module rfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rfa_cfg.sv]
`timescale 1ns / 1ps
module rfa_cfg
  import rfa_pkg::*;
#(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PB    = $clog2(PAGE_BYTES),
  parameter int FNW   = ADDR_W - PB,
  parameter int FNXW  = FNW + 1,
  parameter int IDXW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [ADDR_W-1:0]    cfg_data,
  output logic [FNXW-1:0]      first_fn,
  output logic [FNXW-1:0]      total,
  output logic [FNXW-1:0]      end_fn,
  output logic [IDXW-1:0]      clr_addr,
  output rfa_clr_t             clr
);

  localparam int CLR_LAST = FRAME_COUNT + 2;
  localparam int CCW      = $clog2(CLR_LAST + 1);

  logic [ADDR_W-1:0] range_start_r, range_end_r;
  logic [FNXW-1:0]   s_r, first_fn_r, total_r, end_fn_r;
  logic [FNW-1:0]    e_r;
  logic              busy_r, busy_nxt;
  logic [CCW-1:0]    cnt_r, cnt_nxt;
  logic              hit;
  logic [ADDR_W:0]   s_sum;
  logic [FNXW-1:0]   e_ext, n_raw, total_nxt;
  logic [31:0]       n32;

  assign cfg_ready = 1'b1;
  assign hit = cfg_valid && cfg_ready &&
               (cfg_addr == REG_RANGE_START || cfg_addr == REG_RANGE_END);

  assign s_sum = {1'b0, range_start_r} + (ADDR_W + 1)'(PAGE_BYTES - 1);
  assign e_ext = {1'b0, e_r};
  assign n_raw = (e_ext > s_r) ? (e_ext - s_r) : '0;
  assign n32   = 32'(n_raw);
  assign total_nxt = (n32 > 32'(FRAME_COUNT)) ? FNXW'(FRAME_COUNT) : n_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= '0;
      range_end_r   <= '0;
      s_r           <= '0;
      e_r           <= '0;
      first_fn_r    <= '0;
      total_r       <= '0;
      end_fn_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_addr == REG_RANGE_START) begin
        range_start_r <= cfg_data;
      end
      if (cfg_valid && cfg_ready && cfg_addr == REG_RANGE_END) begin
        range_end_r <= cfg_data;
      end
      s_r        <= s_sum[ADDR_W:PB];
      e_r        <= range_end_r[ADDR_W-1:PB];
      first_fn_r <= s_r;
      total_r    <= total_nxt;
      end_fn_r   <= first_fn_r + total_r;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (hit) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == CCW'(CLR_LAST)) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign clr.busy    = busy_r;
  assign clr.wr      = busy_r && (cnt_r < CCW'(FRAME_COUNT));
  assign clr.done    = busy_r && !hit && (cnt_r == CCW'(CLR_LAST));
  assign clr.restart = hit;
  assign clr_addr    = cnt_r[IDXW-1:0];

  assign first_fn = first_fn_r;
  assign total    = total_r;
  assign end_fn   = end_fn_r;

endmodule

[hw/rtl/refcounted_frame_allocator.sv]
`timescale 1ns / 1ps
// A request is registered into op_r and the EXEC state on its input transfer; its result is
// registered on out_tdata when it leaves EXEC, later while a previous result still waits for out_tready.
// A new request is taken only after the previous one leaves EXEC, set by the read-modify-write of the count RAM.
// Reset and every write of range_start or range_end zero the count RAM in a clearing
// pass, during which in_tready stays low; the stack fill is cleared
// at the start of the pass and the watermark is loaded with the aligned start frame at its end.
module refcounted_frame_allocator
  import rfa_pkg::*;
#(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // fields from bit 0: op[1:0], frame_addr[33:2], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // fields from bit 0: granted_addr[31:0], out_of_memory[32], ref_count[40:33],
  // pages_free[54:41], pages_total[68:55], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [ADDR_W-1:0]      cfg_data
);

  localparam int PB   = $clog2(PAGE_BYTES);
  localparam int FNW  = ADDR_W - PB;
  localparam int FNXW = FNW + 1;
  localparam int IDXW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FLW  = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic [FNXW-1:0] first_fn, total, end_fn;
  logic [IDXW-1:0] clr_addr;
  rfa_clr_t        clr;

  rfa_cfg #(
    .PAGE_BYTES (PAGE_BYTES),
    .FRAME_COUNT(FRAME_COUNT)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .first_fn (first_fn),
    .total    (total),
    .end_fn   (end_fn),
    .clr_addr (clr_addr),
    .clr      (clr)
  );

  logic                   state_r, state_nxt;
  logic [FLW-1:0]         fill_r, fill_nxt, fill_m1;
  logic [FNXW-1:0]        wm_r, wm_nxt;
  logic [OP_W-1:0]        op_r;
  logic                   inr_r, pop_r;
  logic [IDXW-1:0]        idx_r;
  logic [FNW-1:0]         fn_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                   accept, go;
  logic [OP_W-1:0]        in_op;
  logic [ADDR_W-1:0]      in_addr;
  logic [FNXW-1:0]        fn_ext, diff;
  logic [31:0]            diff32;
  logic                   addr_hit;

  logic [COUNT_W-1:0]     cnt_rd;
  logic [FNW-1:0]         stk_rd;
  logic                   got;
  logic [FNXW-1:0]        fn_a, a_diff;
  logic [31:0]            a_diff32;
  logic                   cnt_we;
  logic [IDXW-1:0]        cnt_waddr;
  logic [COUNT_W-1:0]     cnt_new, res_cnt;
  logic                   stk_we;
  logic [ADDR_W-1:0]      granted;
  logic                   oom;
  logic [31:0]            pf32, pt32;

  logic                   ram_we;
  logic [IDXW-1:0]        ram_waddr;
  logic [COUNT_W-1:0]     ram_wdata;

  assign in_op   = in_tdata[OP_W-1:0];
  assign in_addr = in_tdata[OP_W+ADDR_W-1:OP_W];

  assign in_tready = (state_r == ST_IDLE) && !clr.busy;
  assign accept    = in_tvalid && in_tready;
  assign go        = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  assign fn_ext   = {1'b0, in_addr[ADDR_W-1:PB]};
  assign diff     = fn_ext - first_fn;
  assign diff32   = 32'(diff);
  assign addr_hit = (fn_ext >= first_fn) && (diff < total);
  assign fill_m1  = fill_r - 1'b1;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      inr_r <= addr_hit;
      idx_r <= diff32[IDXW-1:0];
      fn_r  <= in_addr[ADDR_W-1:PB];
      pop_r <= (fill_r != '0);
    end
  end

  always_comb begin
    fill_nxt  = fill_r;
    wm_nxt    = wm_r;
    got       = 1'b0;
    fn_a      = pop_r ? {1'b0, stk_rd} : wm_r;
    a_diff    = fn_a - first_fn;
    a_diff32  = 32'(a_diff);
    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_new   = cnt_rd;
    res_cnt   = '0;
    stk_we    = 1'b0;
    granted   = '0;
    oom       = 1'b0;
    case (op_r)
      OP_ALLOC: begin
        got = pop_r || (wm_r < end_fn);
        if (got) begin
          cnt_we    = 1'b1;
          cnt_waddr = a_diff32[IDXW-1:0];
          cnt_new   = COUNT_W'(1);
          res_cnt   = COUNT_W'(1);
          granted   = {fn_a[FNW-1:0], {PB{1'b0}}};
          if (pop_r) begin
            fill_nxt = fill_m1;
          end else begin
            wm_nxt = wm_r + 1'b1;
          end
        end else begin
          oom = 1'b1;
        end
      end
      OP_FREE: begin
        if (inr_r && cnt_rd != '0) begin
          cnt_we  = 1'b1;
          cnt_new = cnt_rd - 1'b1;
          if (cnt_new == '0 && fill_r < FLW'(STACK_DEPTH)) begin
            stk_we   = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
        res_cnt = inr_r ? cnt_new : '0;
      end
      OP_ADD: begin
        if (inr_r && cnt_rd < COUNT_MAX) begin
          cnt_we  = 1'b1;
          cnt_new = cnt_rd + 1'b1;
        end
        res_cnt = inr_r ? cnt_new : '0;
      end
      OP_QUERY: begin
        res_cnt = inr_r ? cnt_rd : '0;
      end
      default: begin
        res_cnt = '0;
      end
    endcase
  end

  assign pf32 = 32'(end_fn) - 32'(wm_nxt) + 32'(fill_nxt);
  assign pt32 = 32'(total);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      wm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr.restart) begin
        fill_r <= '0;
      end else if (go) begin
        fill_r <= fill_nxt;
      end
      if (clr.done) begin
        wm_r <= first_fn;
      end else if (go) begin
        wm_r <= wm_nxt;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= {{(OUT_TDATA_W - 69){1'b0}}, pt32[PAGES_W-1:0], pf32[PAGES_W-1:0],
                     res_cnt, oom, granted};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ram_we    = clr.busy ? clr.wr : (go && cnt_we);
  assign ram_waddr = clr.busy ? clr_addr : cnt_waddr;
  assign ram_wdata = clr.busy ? '0 : cnt_new;

  rfa_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(FRAME_COUNT)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(diff32[IDXW-1:0]),
    .rdata(cnt_rd)
  );

  rfa_ram #(
    .WIDTH(FNW),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (go && stk_we),
    .waddr(fill_r[SW-1:0]),
    .wdata(fn_r),
    .re   (accept),
    .raddr(fill_m1[SW-1:0]),
    .rdata(stk_rd)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FLW'(STACK_DEPTH))
    else $error("free stack fill above depth");

  a_wm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!clr.busy && state_r == ST_EXEC) |-> (wm_r <= end_fn && wm_r >= first_fn))
    else $error("watermark outside managed range");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> (out_tvalid && state_r == ST_IDLE))
    else $error("finished request not presented");

  a_oom_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[31:0] == '0 && out_tdata[40:33] == '0))
    else $error("out of memory result carries a frame");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.restart |=> !in_tready)
    else $error("request taken during clearing pass");

endmodule
